FILE: src/periodic_task_scheduler_core_defines.svh
// Assertion macros for the periodic task scheduler core
`ifndef PERIODIC_TASK_SCHEDULER_CORE_DEFINES_SVH
`define PERIODIC_TASK_SCHEDULER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define PTSC_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ptsc check failed");
`define PTSC_ASSERT_NEVER(name, clk, rst, expr) \
   name: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("ptsc check failed");
`else
`define PTSC_ASSERT_IMPLY(name, clk, rst, ante, cons)
`define PTSC_ASSERT_NEVER(name, clk, rst, expr)
`endif

`endif

FILE: src/ptsc_pkg.sv
package ptsc_pkg;

   localparam int SLOTS_DEFAULT = 16;
   localparam logic [4:0] TARGET_MAX = 5'd25;

   localparam logic [1:0] CMD_TICK     = 2'd0;
   localparam logic [1:0] CMD_SCHEDULE = 2'd1;
   localparam logic [1:0] CMD_KILL     = 2'd2;

   localparam int FLAG_ADDITIVE = 0;
   localparam int FLAG_REPORT   = 1;
   localparam int FLAG_KILLED   = 2;

   localparam logic KIND_FIRE = 1'b0;
   localparam logic KIND_END  = 1'b1;

   typedef struct packed {
      logic [31:0] task_id;
      logic [4:0]  target;
      logic [15:0] interval;
      logic [31:0] runs_left;
      logic [31:0] due_time;
      logic [2:0]  flags;
   } ptsc_entry_type;

   localparam int ENTRY_W = $bits(ptsc_entry_type);

   typedef struct packed {
      logic        kind;
      logic [31:0] task_id;
      logic [4:0]  target;
      logic        report;
      logic [31:0] time_ms;
   } ptsc_event_type;

   typedef struct packed {
      logic accept;
      logic rd;
      logic eval;
      logic push;
      logic push_second;
      logic flush;
      logic finish;
   } ptsc_cmd_type;

   typedef struct packed {
      logic count_zero;
      logic op_tick;
      logic has_ev;
      logic second_ev;
      logic idx_last;
      logic scan_end;
      logic held_valid;
      logic can_push;
      logic out_free;
   } ptsc_stat_type;

endpackage

FILE: src/ptsc_ram.sv
module ptsc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/ptsc_ctrl.sv
module ptsc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic [1:0]             req_command,
   output logic                   req_stall,
   output ptsc_pkg::ptsc_cmd_type cmd,
   input  ptsc_pkg::ptsc_stat_type stat
);
   import ptsc_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_EVAL,
      ST_EMIT1,
      ST_EMIT2,
      ST_FLUSH
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               if ((req_command inside {CMD_TICK, CMD_KILL}) && !stat.count_zero) begin
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            cmd.rd   = 1'b1;
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            if (stat.op_tick && stat.has_ev) begin
               state_in = ST_EMIT1;
            end else if (!stat.idx_last) begin
               state_in = ST_READ;
            end else if (stat.op_tick) begin
               state_in = ST_FLUSH;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT1: begin
            if (stat.can_push) begin
               cmd.push = 1'b1;
               if (stat.second_ev) begin
                  state_in = ST_EMIT2;
               end else if (stat.scan_end) begin
                  state_in = ST_FLUSH;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_EMIT2: begin
            if (stat.can_push) begin
               cmd.push        = 1'b1;
               cmd.push_second = 1'b1;
               state_in = stat.scan_end ? ST_FLUSH : ST_READ;
            end
         end
         ST_FLUSH: begin
            if (!stat.held_valid) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end else if (stat.out_free) begin
               cmd.flush  = 1'b1;
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

FILE: src/ptsc_datapath.sv
module ptsc_datapath #(
   parameter int SLOTS = ptsc_pkg::SLOTS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [1:0]              req_command,
   input  logic [31:0]             req_task_id,
   input  logic [15:0]             req_initial_delay,
   input  logic [15:0]             req_interval,
   input  logic                    req_additive,
   input  logic [31:0]             req_run_count,
   input  logic [4:0]              req_target,
   input  logic                    req_report,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic                    rsp_event_kind,
   output logic [31:0]             rsp_event_task,
   output logic [4:0]              rsp_event_target,
   output logic                    rsp_event_report,
   output logic [31:0]             rsp_event_time,
   output logic                    rsp_last,
   input  ptsc_pkg::ptsc_cmd_type  cmd,
   output ptsc_pkg::ptsc_stat_type stat
);
   import ptsc_pkg::*;

   localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW = $clog2(SLOTS + 1);

   logic [31:0]    now_ff, now_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [CW-1:0]  idx_ff, idx_in;
   logic [CW-1:0]  kept_ff, kept_in;
   logic [31:0]    kill_id_ff, kill_id_in;
   logic           op_tick_ff, op_tick_in;
   logic           ev1_kind_ff, ev1_kind_in;
   logic           ev2_ff, ev2_in;
   logic           held_valid_ff, held_valid_in;
   ptsc_event_type held_ff, held_in;
   logic           out_valid_ff, out_valid_in;
   ptsc_event_type out_ff, out_in;
   logic           out_last_ff, out_last_in;

   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   ptsc_entry_type    wr_entry;
   logic [ENTRY_W-1:0] rd_raw;
   ptsc_entry_type    ent;
   ptsc_entry_type    upd;
   ptsc_entry_type    fresh;
   ptsc_entry_type    marked;
   ptsc_event_type    new_ev;

   logic        due, killed, ends, keep, sched_ok, out_free;
   logic [31:0] runs, runs_dec;

   ptsc_ram #(.WIDTH(ENTRY_W), .DEPTH(SLOTS)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (cmd.rd),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (rd_raw)
   );

   assign ent = ptsc_entry_type'(rd_raw);

   // per-entry tick evaluation and kill mark
   always_comb begin
      killed   = ent.flags[FLAG_KILLED];
      due      = (now_ff >= ent.due_time);
      runs     = (ent.interval == 16'd0) ? 32'd1 : ent.runs_left;
      runs_dec = runs - 32'd1;
      ends     = due && (runs != 32'd0) && (runs_dec == 32'd0);
      keep     = !killed && !ends;
      upd      = ent;
      if (due) begin
         if (runs != 32'd0) begin
            upd.runs_left = runs_dec;
         end
         upd.due_time = ent.flags[FLAG_ADDITIVE] ?
                        (now_ff + {16'd0, ent.interval}) :
                        (ent.due_time + {16'd0, ent.interval});
      end
      marked = ent;
      marked.flags[FLAG_KILLED] = 1'b1;
   end

   always_comb begin
      fresh.task_id   = req_task_id;
      fresh.target    = req_target;
      fresh.interval  = req_interval;
      fresh.runs_left = req_run_count;
      fresh.due_time  = now_ff + {16'd0, req_initial_delay};
      fresh.flags     = '0;
      fresh.flags[FLAG_ADDITIVE] = req_additive;
      fresh.flags[FLAG_REPORT]   = req_report;
      sched_ok = (count_ff < CW'(SLOTS)) && (req_target <= TARGET_MAX);
   end

   always_comb begin
      wr_en    = 1'b0;
      wr_addr  = count_ff[AW-1:0];
      wr_entry = fresh;
      if (cmd.accept && req_command == CMD_SCHEDULE) begin
         wr_en = sched_ok;
      end else if (cmd.eval) begin
         if (op_tick_ff) begin
            wr_en    = keep;
            wr_addr  = kept_ff[AW-1:0];
            wr_entry = upd;
         end else begin
            wr_en    = (ent.task_id == kill_id_ff);
            wr_addr  = idx_ff[AW-1:0];
            wr_entry = marked;
         end
      end
   end

   assign out_free = !out_valid_ff || !rsp_stall;

   always_comb begin
      new_ev.kind    = cmd.push_second ? KIND_END : ev1_kind_ff;
      new_ev.task_id = ent.task_id;
      new_ev.target  = ent.target;
      new_ev.report  = ent.flags[FLAG_REPORT];
      new_ev.time_ms = now_ff;
   end

   always_comb begin
      now_in        = now_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      kept_in       = kept_ff;
      kill_id_in    = kill_id_ff;
      op_tick_in    = op_tick_ff;
      ev1_kind_in   = ev1_kind_ff;
      ev2_in        = ev2_ff;
      held_valid_in = held_valid_ff;
      held_in       = held_ff;
      out_valid_in  = out_valid_ff && rsp_stall;
      out_in        = out_ff;
      out_last_in   = out_last_ff;

      if (cmd.accept) begin
         idx_in  = '0;
         kept_in = '0;
         case (req_command)
            CMD_TICK: begin
               now_in     = now_ff + 32'd1;
               op_tick_in = 1'b1;
            end
            CMD_SCHEDULE: begin
               if (sched_ok) begin
                  count_in = count_ff + CW'(1);
               end
            end
            CMD_KILL: begin
               kill_id_in = req_task_id;
               op_tick_in = 1'b0;
            end
            default: begin
            end
         endcase
      end

      if (cmd.eval) begin
         idx_in      = idx_ff + CW'(1);
         ev1_kind_in = killed ? KIND_END : KIND_FIRE;
         ev2_in      = !killed && ends;
         if (op_tick_ff && keep) begin
            kept_in = kept_ff + CW'(1);
         end
      end

      // held event goes out not-last on a later push, or as last on flush
      if (cmd.push) begin
         if (held_valid_ff) begin
            out_valid_in = 1'b1;
            out_in       = held_ff;
            out_last_in  = 1'b0;
         end
         held_valid_in = 1'b1;
         held_in       = new_ev;
      end

      if (cmd.flush) begin
         out_valid_in  = 1'b1;
         out_in        = held_ff;
         out_last_in   = 1'b1;
         held_valid_in = 1'b0;
      end

      if (cmd.finish) begin
         count_in = kept_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff        <= '0;
         count_ff      <= '0;
         idx_ff        <= '0;
         kept_ff       <= '0;
         op_tick_ff    <= 1'b0;
         held_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         now_ff        <= now_in;
         count_ff      <= count_in;
         idx_ff        <= idx_in;
         kept_ff       <= kept_in;
         op_tick_ff    <= op_tick_in;
         held_valid_ff <= held_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kill_id_ff  <= kill_id_in;
      ev1_kind_ff <= ev1_kind_in;
      ev2_ff      <= ev2_in;
      held_ff     <= held_in;
      out_ff      <= out_in;
      out_last_ff <= out_last_in;
   end

   always_comb begin
      stat.count_zero = (count_ff == '0);
      stat.op_tick    = op_tick_ff;
      stat.has_ev     = killed || due;
      stat.second_ev  = ev2_ff;
      stat.idx_last   = ((idx_ff + CW'(1)) == count_ff);
      stat.scan_end   = (idx_ff == count_ff);
      stat.held_valid = held_valid_ff;
      stat.can_push   = !held_valid_ff || out_free;
      stat.out_free   = out_free;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_event_kind   = out_ff.kind;
   assign rsp_event_task   = out_ff.task_id;
   assign rsp_event_target = out_ff.target;
   assign rsp_event_report = out_ff.report;
   assign rsp_event_time   = out_ff.time_ms;
   assign rsp_last         = out_last_ff;

endmodule

FILE: src/periodic_task_scheduler_core.sv
// Periodic task scheduler: a list of up to SLOTS timed tasks kept in insertion order.
// Input channel req_*: one transfer per command. Schedule appends a task (dropped
// when the list is full or the target is above 25); kill marks every task with
// the given id; tick advances the millisecond counter and scans the list.
// Schedule and kill give no results. A tick gives one rsp_* transfer per fire or
// end event in list order, with rsp_last on the final one; a quiet tick gives none.
// Kill and tick scan the stored tasks one entry at a time through the single
// read / single write port of the task memory: a tick reads each entry, updates
// it and writes it back compacted, and a kill marks the matching ones in place.
// req_stall is high for the whole scan; one item is worked on at a time.
// One finished result waits in the output register and one in a holding stage,
// so a stalled receiver halts the scan at the next event and loses nothing.
// Reset clears the counter, the task count and both result stages; task memory
// needs no clearing pass.
`include "periodic_task_scheduler_core_defines.svh"

module periodic_task_scheduler_core #(
   parameter int SLOTS = ptsc_pkg::SLOTS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_command,
   input  logic [31:0] req_task_id,
   input  logic [15:0] req_initial_delay,
   input  logic [15:0] req_interval,
   input  logic        req_additive,
   input  logic [31:0] req_run_count,
   input  logic [4:0]  req_target,
   input  logic        req_report,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_event_kind,
   output logic [31:0] rsp_event_task,
   output logic [4:0]  rsp_event_target,
   output logic        rsp_event_report,
   output logic [31:0] rsp_event_time,
   output logic        rsp_last
);
   import ptsc_pkg::*;

   ptsc_cmd_type  cmd;
   ptsc_stat_type stat;

   ptsc_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_command),
      .req_stall   (req_stall),
      .cmd         (cmd),
      .stat        (stat)
   );

   ptsc_datapath #(.SLOTS(SLOTS)) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_command       (req_command),
      .req_task_id       (req_task_id),
      .req_initial_delay (req_initial_delay),
      .req_interval      (req_interval),
      .req_additive      (req_additive),
      .req_run_count     (req_run_count),
      .req_target        (req_target),
      .req_report        (req_report),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_event_kind    (rsp_event_kind),
      .rsp_event_task    (rsp_event_task),
      .rsp_event_target  (rsp_event_target),
      .rsp_event_report  (rsp_event_report),
      .rsp_event_time    (rsp_event_time),
      .rsp_last          (rsp_last),
      .cmd               (cmd),
      .stat              (stat)
   );

   // no event may be left in the holding stage once new commands are taken
   `PTSC_ASSERT_NEVER(a_held_flushed, clock, reset, stat.held_valid && !req_stall)
   // results only appear while a tick is being worked on
   `PTSC_ASSERT_IMPLY(a_rsp_from_scan, clock, reset, $rose(rsp_valid), $past(req_stall))
   // nothing is pushed or flushed outside a scan
   `PTSC_ASSERT_NEVER(a_push_in_idle, clock, reset, (cmd.push || cmd.flush) && cmd.accept)

endmodule

FILE: dv/periodic_task_scheduler_core_tb.sv
module periodic_task_scheduler_core_tb;
   import ptsc_pkg::*;

   localparam int NSLOTS     = SLOTS_DEFAULT;
   localparam int IDLE_LIMIT = 4000;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   typedef struct {
      logic [1:0]  cmd;
      logic [31:0] id;
      logic [15:0] delay;
      logic [15:0] interval;
      logic        additive;
      logic [31:0] runs;
      logic [4:0]  target;
      logic        report;
      bit          drain;   // hold back until all events are in
   } sched_cmd_type;

   typedef struct {
      logic        kind;
      logic [31:0] id;
      logic [4:0]  target;
      logic        report;
      logic [31:0] tm;
      logic        last;
   } timer_event_type;

   typedef struct {
      logic [31:0] id;
      logic [4:0]  target;
      logic [15:0] interval;
      logic [31:0] runs_left;
      logic [31:0] due;
      logic        additive;
      logic        report;
      logic        killed;
   } timer_slot_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_command = '0;
   logic [31:0] req_task_id = '0;
   logic [15:0] req_initial_delay = '0;
   logic [15:0] req_interval = '0;
   logic        req_additive = 1'b0;
   logic [31:0] req_run_count = '0;
   logic [4:0]  req_target = '0;
   logic        req_report = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_event_kind;
   logic [31:0] rsp_event_task;
   logic [4:0]  rsp_event_target;
   logic        rsp_event_report;
   logic [31:0] rsp_event_time;
   logic        rsp_last;

   sched_cmd_type   pending_cmds[$];
   timer_event_type expected_events[$];
   timer_slot_type  timer_list[NSLOTS];
   logic [31:0]     model_now;
   int              model_count;

   sched_cmd_type cur_cmd;
   int           burst_left = 8;
   int           gap_left = 0;
   int           stall_mode = 0;
   int           hold_left = 0;
   int           stall_cycles = 0;
   int           idle_cycles = 0;
   int           errors = 0;
   int           n_ticks = 0;
   int           n_scheds = 0;
   int           n_kills = 0;
   int           n_fires = 0;
   int           n_ends = 0;

   periodic_task_scheduler_core i_dut (.*);

   always #5 clock = ~clock;

   function automatic void predict_events(sched_cmd_type c);
      int              kept;
      logic            keep;
      int              first;
      timer_event_type ev;
      first = expected_events.size();
      case (c.cmd)
         CMD_SCHEDULE: begin
            n_scheds++;
            if (model_count < NSLOTS && c.target <= TARGET_MAX) begin
               timer_list[model_count] = '{c.id, c.target, c.interval, c.runs,
                  model_now + 32'(c.delay), c.additive, c.report, 1'b0};
               model_count++;
            end
         end
         CMD_KILL: begin
            n_kills++;
            for (int i = 0; i < model_count; i++)
               if (timer_list[i].id == c.id) timer_list[i].killed = 1'b1;
         end
         CMD_TICK: begin
            n_ticks++;
            model_now = model_now + 32'd1;
            kept = 0;
            for (int i = 0; i < model_count; i++) begin
               keep = 1'b1;
               ev = '{KIND_END, timer_list[i].id, timer_list[i].target,
                      timer_list[i].report, model_now, 1'b0};
               if (timer_list[i].killed) begin
                  expected_events.push_back(ev);
                  keep = 1'b0;
               end else if (model_now >= timer_list[i].due) begin
                  if (timer_list[i].interval == 16'd0) timer_list[i].runs_left = 32'd1;
                  ev.kind = KIND_FIRE;
                  expected_events.push_back(ev);
                  if (timer_list[i].runs_left > 32'd0) begin
                     timer_list[i].runs_left--;
                     if (timer_list[i].runs_left == 32'd0) begin
                        ev.kind = KIND_END;
                        expected_events.push_back(ev);
                        keep = 1'b0;
                     end
                  end
                  if (keep)
                     timer_list[i].due = (timer_list[i].additive ? model_now
                        : timer_list[i].due) + 32'(timer_list[i].interval);
               end
               if (keep) begin
                  timer_list[kept] = timer_list[i];
                  kept++;
               end
            end
            model_count = kept;
            if (expected_events.size() > first)
               expected_events[expected_events.size() - 1].last = 1'b1;
         end
         default: ;
      endcase
   endfunction

   // sender: bursts and gaps, holds a stalled transfer
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) predict_events(cur_cmd);
         if (req_valid && req_stall) begin
         end else if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_cmds.size() > 0 &&
                      !(pending_cmds[0].drain && expected_events.size() > 0)) begin
            cur_cmd = pending_cmds.pop_front();
            req_command       <= cur_cmd.cmd;
            req_task_id       <= cur_cmd.id;
            req_initial_delay <= cur_cmd.delay;
            req_interval      <= cur_cmd.interval;
            req_additive      <= cur_cmd.additive;
            req_run_count     <= cur_cmd.runs;
            req_target        <= cur_cmd.target;
            req_report        <= cur_cmd.report;
            req_valid         <= 1'b1;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 40);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver stall pattern, with one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         stall_cycles++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_cycles == 2500) begin
            hold_left = 800;
            rsp_stall <= 1'b1;
         end else begin
            if (stall_cycles % 150 == 0) stall_mode = $urandom_range(0, 2);
            rsp_stall <= (stall_mode == 0) ? 1'b0 :
                         (stall_mode == 1) ? ($urandom_range(0, 3) == 0) :
                                             ($urandom_range(0, 3) != 0);
         end
      end
   end

   task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected %0h, got %0h", name, exp_v, act_v);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      timer_event_type ev;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_events.size() == 0) begin
            $error("event transfer with nothing expected: task %0h", rsp_event_task);
            errors++;
         end else begin
            ev = expected_events.pop_front();
            check_field("event_kind", 32'(ev.kind), 32'(rsp_event_kind));
            check_field("event_task", ev.id, rsp_event_task);
            check_field("event_target", 32'(ev.target), 32'(rsp_event_target));
            check_field("event_report", 32'(ev.report), 32'(rsp_event_report));
            check_field("event_time", ev.tm, rsp_event_time);
            check_field("last", 32'(ev.last), 32'(rsp_last));
            if (ev.kind == KIND_FIRE) n_fires++;
            else n_ends++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles = 0;
      else if (++idle_cycles >= IDLE_LIMIT) begin
         $display("timed out with %0d events outstanding", expected_events.size());
         $display("periodic_task_scheduler_core regression: fail");
         $finish;
      end
   end

   task automatic add_cmd(logic [1:0] cmd, logic [31:0] id, logic [15:0] delay,
                          logic [15:0] interval, logic additive, logic [31:0] runs,
                          logic [4:0] target, logic report);
      sched_cmd_type c;
      c = '{cmd, id, delay, interval, additive, runs, target, report, 1'b0};
      pending_cmds.push_back(c);
   endtask

   function automatic logic [31:0] pick_id();
      case ($urandom_range(0, 9))
         0:       return 32'hFFFF_FFFF;
         1:       return $urandom;
         default: return $urandom_range(0, 7);
      endcase
   endfunction

   initial begin
      sched_cmd_type c;
      logic [31:0]   rnd;
      model_now = '0;
      model_count = 0;

      // directed: field extremes, dropped schedules, unknown command, kills
      add_cmd(CMD_SCHEDULE, 32'h0, 16'd0, 16'd0, 1'b0, 32'd5, 5'd0, 1'b1);
      add_cmd(CMD_SCHEDULE, 32'hFFFF_FFFF, 16'd1, 16'd2, 1'b1, 32'd3, 5'd25, 1'b0);
      add_cmd(CMD_SCHEDULE, 32'd7, 16'hFFFF, 16'hFFFF, 1'b0, 32'hFFFF_FFFF, 5'd3, 1'b1);
      add_cmd(CMD_SCHEDULE, 32'd9, 16'd0, 16'd1, 1'b0, 32'd0, 5'd26, 1'b0);
      add_cmd(CMD_SCHEDULE, 32'd9, 16'd2, 16'd1, 1'b0, 32'd0, 5'd31, 1'b1);
      add_cmd(CMD_SCHEDULE, 32'd5, 16'd0, 16'd1, 1'b0, 32'd0, 5'd10, 1'b1);
      add_cmd(CMD_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b1, 32'hFFFF_FFFF, 5'd31,
              1'b1);
      add_cmd(CMD_KILL, 32'd12345, '0, '0, 1'b0, '0, '0, 1'b0);
      add_cmd(CMD_TICK, '0, '0, '0, 1'b0, '0, '0, 1'b0);
      add_cmd(CMD_TICK, '0, '0, '0, 1'b0, '0, '0, 1'b0);
      add_cmd(CMD_KILL, 32'd5, '0, '0, 1'b0, '0, '0, 1'b0);  // killed while due
      add_cmd(CMD_TICK, '0, '0, '0, 1'b0, '0, '0, 1'b0);
      add_cmd(CMD_TICK, '0, '0, '0, 1'b0, '0, '0, 1'b0);
      // full list: the last schedules are dropped
      for (int i = 0; i < 17; i++)
         add_cmd(CMD_SCHEDULE, 32'd100 + 32'(i), 16'd2, 16'd0, i[0], 32'd0, 5'(i), 1'b0);
      add_cmd(CMD_TICK, '0, '0, '0, 1'b0, '0, '0, 1'b0);
      add_cmd(CMD_TICK, '0, '0, '0, 1'b0, '0, '0, 1'b0);

      for (int n = 0; n < 430; n++) begin
         rnd = $urandom_range(0, 99);
         c.id       = pick_id();
         c.delay    = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 5));
         c.interval = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4));
         c.additive = 1'($urandom_range(0, 1));
         c.runs     = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 4);
         c.target   = ($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'($urandom_range(0, 25));
         c.report   = 1'($urandom_range(0, 1));
         c.drain    = (n == 200);
         c.cmd      = (rnd < 48) ? CMD_TICK : (rnd < 84) ? CMD_SCHEDULE :
                      (rnd < 97) ? CMD_KILL : CMD_UNUSED;
         pending_cmds.push_back(c);
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      wait (pending_cmds.size() == 0);
      @(posedge clock);
      while (req_valid) @(posedge clock);
      while (expected_events.size() > 0) @(posedge clock);
      repeat (100) @(posedge clock);

      $display("covered %0d ticks, %0d schedules, %0d kills", n_ticks, n_scheds, n_kills);
      $display("checked %0d fire and %0d end events", n_fires, n_ends);
      if (errors == 0 && expected_events.size() == 0)
         $display("periodic_task_scheduler_core regression: pass");
      else
         $display("periodic_task_scheduler_core regression: fail");
      $finish;
   end

endmodule
